/* rtl/rgb_blink_sequencer_assert.svh */
// Assertion macros shared by the blink sequencer RTL.
`ifndef RGB_BLINK_SEQUENCER_ASSERT_SVH
`define RGB_BLINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RBS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rbs_pkg.sv */
// Types, constants and the microcode table of the RGB blink sequencer.
package rbs_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int LANE_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int TABLE_W      = 32;
  localparam int COLOR_W      = 24;
  localparam int PAIR_W       = 48;
  localparam int COUNT_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 40;

  localparam logic [TABLE_W-1:0] SPEED_RESET = 32'h0101_0101;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_CLR_TICK = 2'd1,
    KIND_CLR_RUN  = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED    = 3'd0,
    REG_START    = 3'd1,
    REG_END      = 3'd2,
    REG_CLEAR    = 3'd3,
    REG_ENABLE   = 3'd4,
    REG_COLOR_LO = 3'd5,
    REG_COLOR_HI = 3'd6
  } cfg_reg_t;

  // Microprogram addresses.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_LOAD = 3'd1,
    ST_DIV  = 3'd2,
    ST_EVAL = 3'd3,
    ST_NEXT = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    JMP_WAIT_IN,
    JMP_DIV_LOOP,
    JMP_WAIT_OUT,
    JMP_NEXT_CH,
    JMP_ADVANCE
  } jmp_t;

  typedef struct packed {
    logic  load;
    logic  div;
    logic  eval;
    logic  next_ch;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w = '{load: 1'b0, div: 1'b0, eval: 1'b0, next_ch: 1'b0,
          jmp: JMP_WAIT_IN, target: ST_IDLE};
    case (pc)
      ST_IDLE: begin
        w.jmp    = JMP_WAIT_IN;
        w.target = ST_LOAD;
      end
      ST_LOAD: begin
        w.load = 1'b1;
        w.jmp  = JMP_ADVANCE;
      end
      ST_DIV: begin
        w.div = 1'b1;
        w.jmp = JMP_DIV_LOOP;
      end
      ST_EVAL: begin
        w.eval = 1'b1;
        w.jmp  = JMP_WAIT_OUT;
      end
      ST_NEXT: begin
        w.next_ch = 1'b1;
        w.jmp     = JMP_NEXT_CH;
        w.target  = ST_LOAD;
      end
      default: begin
        w.jmp    = JMP_NEXT_CH;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/rgb_blink_sequencer.sv */
// RGB blink sequencer top level: microcoded channel walker with a serial divider.
//
// A tick transaction walks the channels in order and produces one result per
// channel; the last one carries out_tlast. Each channel goes through load,
// the divider loop, result and advance; the result step waits while the
// output register holds a result and out_tready is low. The divider loop
// is the restoring divider that retires two quotient bits per cycle. Clear
// transactions and the unused kind are taken at the idle step and produce no
// result. Input is taken only when the sequencer is back at its idle step; a
// finished result waiting in the output register does not hold off input.
`include "rgb_blink_sequencer_assert.svh"

module rgb_blink_sequencer #(
  parameter int CHANNELS = rbs_pkg::MAX_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] kind, [3:2] channel, [7:4] zero
  input  logic [rbs_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] lane, [9:2] red, [17:10] green, [25:18] blue, [33:26] runs, [39:34] zero
  output logic [rbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbs_pkg::PAIR_W-1:0]        cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BW    = rbs_pkg::BYTE_W;
  localparam int CW    = rbs_pkg::COUNT_W;
  localparam int LW    = rbs_pkg::LANE_W;

  // Configuration registers.
  logic [rbs_pkg::TABLE_W-1:0] speed_r, start_r, end_r, clear_r;
  logic [rbs_pkg::MAX_CHANNELS-1:0] enable_r;
  logic [rbs_pkg::PAIR_W-1:0] color_lo_r, color_hi_r;

  // Per-channel state.
  logic [CW-1:0] tick_r [CHANNELS];
  logic [BW-1:0] run_r  [CHANNELS];

  // Sequencer.
  rbs_pkg::step_t pc_r, pc_nxt;
  rbs_pkg::ctrl_t cw;
  logic [LW-1:0]  ch_r;
  logic [IDX_W-1:0] ch_idx;

  // Datapath registers.
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] quo_r;
  logic [BW-1:0] rem_r;
  logic [BW-1:0] divisor_r;
  logic [2:0]    div_cnt_r;

  logic            out_valid_r;
  logic [LW-1:0]   lane_r;
  logic [BW-1:0]   red_r, green_r, blue_r, runs_r;
  logic            last_r;

  logic            in_acc, tick_acc, clr_ok, out_free, last_ch, eval_fire;
  rbs_pkg::kind_t  in_kind;
  logic [LW-1:0]   in_chan;
  logic [IDX_W-1:0] in_idx;

  logic [BW-1:0] speed_b, start_b, end_b, clear_b, step;
  logic [rbs_pkg::PAIR_W-1:0]  pair;
  logic [rbs_pkg::COLOR_W-1:0] color;
  logic [8:0] r1, r2;
  logic [BW-1:0] r1m, r2m;
  logic q1, q2;
  logic enabled, lit, wrap;
  logic [BW-1:0] run_inc;

  assign cw       = rbs_pkg::ucode(pc_r);
  assign ch_idx   = ch_r[IDX_W-1:0];
  assign in_tready = (pc_r == rbs_pkg::ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign in_kind  = rbs_pkg::kind_t'(in_tdata[1:0]);
  assign in_chan  = in_tdata[3:2];
  assign in_idx   = in_chan[IDX_W-1:0];
  assign clr_ok   = ({1'b0, in_chan} < 3'(CHANNELS));
  assign tick_acc = in_acc && (in_kind == rbs_pkg::KIND_TICK);
  assign out_free = !out_valid_r || out_tready;
  assign last_ch  = (ch_r == LW'(CHANNELS - 1));
  assign eval_fire = cw.eval && out_free;

  // Per-channel field selection.
  assign speed_b = speed_r[{ch_r, 3'b000} +: BW];
  assign start_b = start_r[{ch_r, 3'b000} +: BW];
  assign end_b   = end_r[{ch_r, 3'b000} +: BW];
  assign clear_b = clear_r[{ch_r, 3'b000} +: BW];
  assign pair    = ch_r[1] ? color_hi_r : color_lo_r;
  assign color   = ch_r[0] ? pair[47:24] : pair[23:0];

  // Two restoring division steps per cycle.
  always_comb begin
    r1  = {rem_r, quo_r[CW-1]};
    q1  = (r1 >= {1'b0, divisor_r});
    r1m = q1 ? BW'(r1 - {1'b0, divisor_r}) : r1[BW-1:0];
    r2  = {r1m, quo_r[CW-2]};
    q2  = (r2 >= {1'b0, divisor_r});
    r2m = q2 ? BW'(r2 - {1'b0, divisor_r}) : r2[BW-1:0];
  end

  // Result evaluation; the low quotient byte is the step.
  assign step    = quo_r[BW-1:0];
  assign enabled = enable_r[ch_r];
  assign wrap    = (step >= clear_b);
  assign lit     = enabled && (step >= start_b) && (step < end_b);
  assign run_inc = run_r[ch_idx] + 8'd1;

  // Microsequencer next address.
  always_comb begin
    pc_nxt = pc_r;
    case (cw.jmp)
      rbs_pkg::JMP_WAIT_IN:  pc_nxt = tick_acc ? cw.target : pc_r;
      rbs_pkg::JMP_DIV_LOOP: pc_nxt = (div_cnt_r == 3'd7) ? rbs_pkg::step_t'(pc_r + 3'd1) : pc_r;
      rbs_pkg::JMP_WAIT_OUT: pc_nxt = out_free ? rbs_pkg::step_t'(pc_r + 3'd1) : pc_r;
      rbs_pkg::JMP_NEXT_CH:  pc_nxt = last_ch ? rbs_pkg::ST_IDLE : cw.target;
      rbs_pkg::JMP_ADVANCE:  pc_nxt = rbs_pkg::step_t'(pc_r + 3'd1);
      default:               pc_nxt = rbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rbs_pkg::ST_IDLE;
      ch_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.next_ch) begin
        ch_r <= last_ch ? '0 : LW'(ch_r + 2'd1);
      end
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= rbs_pkg::SPEED_RESET;
      start_r    <= '0;
      end_r      <= '0;
      clear_r    <= '0;
      enable_r   <= '0;
      color_lo_r <= '0;
      color_hi_r <= '0;
    end else if (cfg_we) begin
      case (rbs_pkg::cfg_reg_t'(cfg_index))
        rbs_pkg::REG_SPEED:    speed_r    <= cfg_wdata[rbs_pkg::TABLE_W-1:0];
        rbs_pkg::REG_START:    start_r    <= cfg_wdata[rbs_pkg::TABLE_W-1:0];
        rbs_pkg::REG_END:      end_r      <= cfg_wdata[rbs_pkg::TABLE_W-1:0];
        rbs_pkg::REG_CLEAR:    clear_r    <= cfg_wdata[rbs_pkg::TABLE_W-1:0];
        rbs_pkg::REG_ENABLE:   enable_r   <= cfg_wdata[rbs_pkg::MAX_CHANNELS-1:0];
        rbs_pkg::REG_COLOR_LO: color_lo_r <= cfg_wdata;
        rbs_pkg::REG_COLOR_HI: color_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel state: clears come in at idle, updates at the result step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        tick_r[i] <= '0;
        run_r[i]  <= '0;
      end
    end else if (in_acc && clr_ok && (in_kind == rbs_pkg::KIND_CLR_TICK)) begin
      tick_r[in_idx] <= '0;
    end else if (in_acc && clr_ok && (in_kind == rbs_pkg::KIND_CLR_RUN)) begin
      run_r[in_idx] <= '0;
    end else if (eval_fire) begin
      if (!enabled || wrap) begin
        tick_r[ch_idx] <= '0;
      end else begin
        tick_r[ch_idx] <= cnt_r;
      end
      if (enabled && wrap) begin
        run_r[ch_idx] <= run_inc;
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (cw.load) begin
      cnt_r     <= CW'(tick_r[ch_idx] + 16'd1);
      quo_r     <= CW'(tick_r[ch_idx] + 16'd1);
      rem_r     <= '0;
      divisor_r <= (speed_b == '0) ? 8'd1 : speed_b;
      div_cnt_r <= '0;
    end else if (cw.div) begin
      quo_r     <= {quo_r[CW-3:0], q1, q2};
      rem_r     <= r2m;
      div_cnt_r <= div_cnt_r + 3'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eval_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      lane_r  <= ch_r;
      red_r   <= lit ? color[7:0]   : 8'd0;
      green_r <= lit ? color[15:8]  : 8'd0;
      blue_r  <= lit ? color[23:16] : 8'd0;
      runs_r  <= (enabled && wrap) ? run_inc : run_r[ch_idx];
      last_r  <= last_ch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, runs_r, blue_r, green_r, red_r, lane_r};
  assign out_tlast  = last_r;

  `RBS_ASSERT_IMPL(a_idle_ch0, pc_r == rbs_pkg::ST_IDLE, ch_r == '0, "channel walk not rewound")
  `RBS_ASSERT_NEXT(a_tick_starts, tick_acc, pc_r == rbs_pkg::ST_LOAD, "tick did not start walk")
  `RBS_ASSERT_NEXT(a_walk_ends, (pc_r == rbs_pkg::ST_NEXT) && last_ch, pc_r == rbs_pkg::ST_IDLE, "walk did not end after last channel")
  `RBS_ASSERT_NEXT(a_result_loaded, eval_fire, out_valid_r && (lane_r == $past(ch_r)), "result not loaded for current channel")

endmodule
